>>> hdl/mtbc_pkg.sv
`timescale 1ns / 1ps

package mtbc_pkg;

    // Default sizes
    localparam int MAX_NAME_DEF    = 16;
    localparam int STACK_DEPTH_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_OPEN    = 8'd60;   // '<'
    localparam logic [7:0] CH_CLOSE   = 8'd62;   // '>'
    localparam logic [7:0] CH_SLASH   = 8'd47;   // '/'
    localparam logic [7:0] CH_LOW_B   = 8'd98;   // 'b'
    localparam logic [7:0] CH_LOW_H   = 8'd104;  // 'h'
    localparam logic [7:0] CH_LOW_R   = 8'd114;  // 'r'

    // Stack shift control, common to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    // Name collector control
    typedef struct packed {
        logic clear;
        logic append;
    } t_name_ctl;

    // Name collector status toward the control logic
    typedef struct packed {
        logic full;       // buffer holds MAX_NAME bytes
        logic too_long;   // a byte was dropped in this tag
        logic skip;       // exact "br" or "hr"
        logic is_close;   // name starts with '/'
        logic top_match;  // "/x" with x equal to the top stacked name
    } t_name_stat;

endpackage

>>> hdl/mtbc_cell.sv
`timescale 1ns / 1ps

module mtbc_cell import mtbc_pkg::*; #(
    parameter int NAME_W = MAX_NAME_DEF * 8,
    parameter int LEN_W  = $clog2(MAX_NAME_DEF + 1)
) (
    input  logic              i_clk,
    input  t_stk_ctl          i_ctl,
    input  logic [NAME_W-1:0] i_above_chars,  // entry nearer the top
    input  logic [LEN_W-1:0]  i_above_len,
    input  logic [NAME_W-1:0] i_below_chars,  // entry nearer the bottom
    input  logic [LEN_W-1:0]  i_below_len,
    output logic [NAME_W-1:0] o_chars,
    output logic [LEN_W-1:0]  o_len
);

    logic [NAME_W-1:0] r_chars;
    logic [LEN_W-1:0]  r_len;

    // Push moves entries down one cell, pop moves them up one cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_chars <= i_above_chars;
            r_len   <= i_above_len;
        end else if (i_ctl.pop) begin
            r_chars <= i_below_chars;
            r_len   <= i_below_len;
        end
    end

    assign o_chars = r_chars;
    assign o_len   = r_len;

endmodule

>>> hdl/mtbc_name.sv
`timescale 1ns / 1ps

module mtbc_name import mtbc_pkg::*; #(
    parameter int MAX_NAME = MAX_NAME_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_name_ctl                          i_ctl,
    input  logic [7:0]                         i_byte,
    input  logic [MAX_NAME*8-1:0]              i_top_chars,
    input  logic [$clog2(MAX_NAME+1)-1:0]      i_top_len,
    output t_name_stat                         o_stat,
    output logic [MAX_NAME*8-1:0]              o_chars,
    output logic [$clog2(MAX_NAME+1)-1:0]      o_len
);

    localparam int NAME_W = MAX_NAME * 8;
    localparam int LEN_W  = $clog2(MAX_NAME + 1);
    localparam int IDX_W  = $clog2(MAX_NAME);

    logic [NAME_W-1:0] r_buf;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_too_long, n_too_long;
    logic              w_full;
    logic              w_len_ok;
    logic              w_bytes_ok;
    logic [LEN_W:0]    w_top_len_p1;

    assign w_full = (r_len == LEN_W'(MAX_NAME));

    // Length and overflow flag
    always_comb begin
        n_len      = r_len;
        n_too_long = r_too_long;
        if (i_ctl.clear) begin
            n_len      = '0;
            n_too_long = 1'b0;
        end else if (i_ctl.append) begin
            if (w_full) begin
                n_too_long = 1'b1;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_too_long <= n_too_long;
        end
    end

    // Byte write at the current length
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_NAME; k++) begin
            if (i_ctl.append && !w_full && r_len[IDX_W-1:0] == IDX_W'(k)) begin
                r_buf[k*8 +: 8] <= i_byte;
            end
        end
    end

    // Parallel compare of "/x" against the top stacked name
    assign w_top_len_p1 = {1'b0, i_top_len} + (LEN_W+1)'(1);
    assign w_len_ok     = (w_top_len_p1 == {1'b0, r_len});

    always_comb begin
        w_bytes_ok = 1'b1;
        for (int k = 0; k < MAX_NAME - 1; k++) begin
            if (LEN_W'(k) < i_top_len && i_top_chars[k*8 +: 8] != r_buf[(k+1)*8 +: 8]) begin
                w_bytes_ok = 1'b0;
            end
        end
    end

    assign o_stat.full      = w_full;
    assign o_stat.too_long  = r_too_long;
    assign o_stat.skip      = (r_len == LEN_W'(2)) && (r_buf[15:8] == CH_LOW_R) &&
                              (r_buf[7:0] == CH_LOW_B || r_buf[7:0] == CH_LOW_H);
    assign o_stat.is_close  = (r_len != '0) && (r_buf[7:0] == CH_SLASH);
    assign o_stat.top_match = w_len_ok && w_bytes_ok;

    assign o_chars = r_buf;
    assign o_len   = r_len;

endmodule

>>> hdl/markup_tag_balance_checker_unit.sv
`timescale 1ns / 1ps

// Markup tag balance checker.
// Input stream: one character byte per beat on the s_axis group (tdata = char_in).
// Output stream: one verdict beat per newline seen outside a tag on the m_axis
// group (tdata bit 0: 0 tags balanced, 1 unbalanced or error).
// Tag names collect in a name buffer; opening names are pushed onto a stack
// built as a row of STACK_DEPTH cells that shift down on push and up on pop.
// The top cell is compared with a closing name combinationally, all bytes at once.
// Throughput: one character per cycle while input is not stalled, as push, pop and
// top compare in the cell row need no multi-step sequence. The verdict is valid in
// the cycle after the newline beat is accepted, held in a one-entry output register.
// When the receiver stalls, the verdict waits in that register; input keeps
// flowing while the register is empty or being drained this cycle, so input
// stalls only when a verdict is pending and i_m_axis_tready is low.
// Reset (synchronous, active low) empties the stack, clears the error flag,
// leaves the outside-tag state and drops any pending verdict. No clearing
// pass is needed; the block accepts input in the first cycle after reset.

module markup_tag_balance_checker_unit import mtbc_pkg::*; #(
    parameter int MAX_NAME    = MAX_NAME_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] verdict, [7:1] zero
);

    localparam int NAME_W = MAX_NAME * 8;
    localparam int LEN_W  = $clog2(MAX_NAME + 1);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic              r_inside, n_inside;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_err, n_err;
    logic              r_out_valid, n_out_valid;
    logic              r_verdict, n_verdict;

    logic              w_beat;
    t_stk_ctl          w_stk_ctl;
    t_name_ctl         w_name_ctl;
    t_name_stat        w_stat;
    logic [NAME_W-1:0] w_name_chars;
    logic [LEN_W-1:0]  w_name_len;
    logic [NAME_W-1:0] w_chars [STACK_DEPTH];
    logic [LEN_W-1:0]  w_len   [STACK_DEPTH];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_beat          = i_s_axis_tvalid && o_s_axis_tready;

    // Name collector with top-of-stack compare
    mtbc_name #(
        .MAX_NAME (MAX_NAME)
    ) u_name (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_name_ctl),
        .i_byte      (i_s_axis_tdata),
        .i_top_chars (w_chars[0]),
        .i_top_len   (w_len[0]),
        .o_stat      (w_stat),
        .o_chars     (w_name_chars),
        .o_len       (w_name_len)
    );

    // Stack row: cell 0 is the top
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [NAME_W-1:0] w_above_chars, w_below_chars;
        logic [LEN_W-1:0]  w_above_len, w_below_len;

        if (i == 0) begin : g_top
            assign w_above_chars = w_name_chars;
            assign w_above_len   = w_name_len;
        end else begin : g_mid
            assign w_above_chars = w_chars[i-1];
            assign w_above_len   = w_len[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_bot
            assign w_below_chars = w_chars[i];
            assign w_below_len   = w_len[i];
        end else begin : g_up
            assign w_below_chars = w_chars[i+1];
            assign w_below_len   = w_len[i+1];
        end

        mtbc_cell #(
            .NAME_W (NAME_W),
            .LEN_W  (LEN_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_stk_ctl),
            .i_above_chars (w_above_chars),
            .i_above_len   (w_above_len),
            .i_below_chars (w_below_chars),
            .i_below_len   (w_below_len),
            .o_chars       (w_chars[i]),
            .o_len         (w_len[i])
        );
    end

    // Per-character control
    always_comb begin
        n_inside    = r_inside;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_verdict   = r_verdict;
        w_stk_ctl   = '0;
        w_name_ctl  = '0;

        if (w_beat) begin
            if (!r_inside) begin
                if (i_s_axis_tdata == CH_NEWLINE) begin
                    n_out_valid       = 1'b1;
                    n_verdict         = (r_cnt != '0) || r_err;
                    n_cnt             = '0;
                    n_err             = 1'b0;
                    w_name_ctl.clear  = 1'b1;
                end else if (i_s_axis_tdata == CH_OPEN) begin
                    n_inside          = 1'b1;
                    w_name_ctl.clear  = 1'b1;
                end
            end else if (i_s_axis_tdata == CH_CLOSE) begin
                n_inside         = 1'b0;
                w_name_ctl.clear = 1'b1;
                if (!w_stat.too_long && !w_stat.skip) begin
                    if (!w_stat.is_close) begin
                        if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                            n_err = 1'b1;
                        end else begin
                            w_stk_ctl.push = 1'b1;
                            n_cnt          = r_cnt + CNT_W'(1);
                        end
                    end else if (r_cnt == '0) begin
                        n_err = 1'b1;
                    end else if (w_stat.top_match) begin
                        w_stk_ctl.pop = 1'b1;
                        n_cnt         = r_cnt - CNT_W'(1);
                    end
                end
            end else begin
                w_name_ctl.append = 1'b1;
                if (w_stat.full) begin
                    n_err = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inside    <= n_inside;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_verdict};

endmodule

>>> hdl/mtbc_checker.sv
`timescale 1ns / 1ps

module mtbc_checker import mtbc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // A stalled verdict beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("verdict beat dropped or changed while stalled");

    // A new verdict only follows an accepted newline
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready) && $past(i_s_axis_tdata) == CH_NEWLINE)
        else $error("verdict without a newline beat");

    // Padding bits stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:1] == 7'd0)
        else $error("verdict padding not zero");

    // Input is taken whenever no verdict is pending
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    // Reset drops any pending verdict
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("verdict valid right after reset");

endmodule

bind markup_tag_balance_checker_unit mtbc_checker u_mtbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
